FILE: rtl/fsng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsng_pkg
// Shared types and constants of the spectral noise gate core.
// ----------------------------------------------------------------------------
package fsng_pkg;

    localparam int FRAME_SIZE_DEF = 64;
    localparam logic [19:0] GATE_THRESHOLD_RST = 20'd1000;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam longint unsigned COS_DIV [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };
    localparam longint unsigned SIN_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_BF_M0,
        ST_BF_M1,
        ST_BF_M2,
        ST_BF_M3,
        ST_BF_M4,
        ST_BF_WA,
        ST_BF_WB,
        ST_GT_TH,
        ST_GT_RD,
        ST_GT_S0,
        ST_GT_S1,
        ST_GT_S2,
        ST_GT_S3,
        ST_GT_S4,
        ST_GT_WA,
        ST_GT_WB,
        ST_OUT_RD,
        ST_OUT_EM
    } fsng_state_t;

endpackage

FILE: rtl/fft_spectral_noise_gate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_spectral_noise_gate_core
// Frame FFT, squared-magnitude spectral gate, inverse FFT and rounded output.
// ----------------------------------------------------------------------------
// Samples load one per cycle while busy is low; the last one of a frame starts processing.
// One butterfly runs through ST_BF_RD, ST_BF_M0 to ST_BF_M4, ST_BF_WA and ST_BF_WB on the shared
// multiplier, in the forward and in the inverse transform. The gate pass runs ST_GT_RD, ST_GT_S0 to
// ST_GT_S4, ST_GT_WA and ST_GT_WB per bin pair and only ST_GT_RD per skipped index, after the ST_GT_TH
// setup state; each result is then read in ST_OUT_RD and emitted in ST_OUT_EM.
// Results cannot be stalled. Reset clears control state and sets the threshold to 1000.
module fft_spectral_noise_gate_core
#(
    parameter int FRAME_SIZE = fsng_pkg::FRAME_SIZE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [19:0] cfg_data,
    output logic               result_valid,
    output logic signed [15:0] cleaned_sample,
    output logic               last_in_frame
);
    import fsng_pkg::*;

    localparam int LOG2N  = $clog2(FRAME_SIZE);
    localparam int AW     = LOG2N;
    localparam int HALF_N = (FRAME_SIZE / 2 > 0) ? FRAME_SIZE / 2 : 1;
    localparam int TW_AW  = (LOG2N > 1) ? LOG2N - 1 : 1;
    localparam int SW     = (LOG2N > 1) ? $clog2(LOG2N) : 1;

    function automatic logic [15:0] q30_to_q15(input longint v);
        longint q;
        if (v >= 0)
            q = (v + 64'sd16384) >>> 15;
        else
            q = -((-v + 64'sd16384) >>> 15);
        if (q > 64'sd32767)
            q = 64'sd32767;
        if (q < -64'sd32768)
            q = -64'sd32768;
        return q[15:0];
    endfunction

    function automatic logic [31:0] tw_entry(input int unsigned k);
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint c;
        longint s;
        bit neg;
        kk  = k;
        neg = 1'b0;
        if (4 * kk > FRAME_SIZE)
        begin
            kk  = FRAME_SIZE / 2 - kk;
            neg = 1'b1;
        end
        x  = (64'd2 * PI_Q30 * kk + FRAME_SIZE / 2) / FRAME_SIZE;
        x2 = (x * x) >> 30;
        tc = 64'd1 << 30;
        ts = x;
        c  = longint'(tc);
        s  = longint'(ts);
        for (int t = 1; t <= 12; t++)
        begin
            tc = ((tc * x2) >> 30) / COS_DIV[t - 1];
            ts = ((ts * x2) >> 30) / SIN_DIV[t - 1];
            if (t % 2 == 1)
            begin
                c = c - longint'(tc);
                s = s - longint'(ts);
            end
            else
            begin
                c = c + longint'(tc);
                s = s + longint'(ts);
            end
        end
        return {q30_to_q15(neg ? -c : c), q30_to_q15(s)};
    endfunction

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++)
            r[AW - 1 - b] = v[b];
        return r;
    endfunction

    logic [31:0] tw_rom [HALF_N];
    for (genvar g = 0; g < HALF_N; g++)
    begin : g_tw
        localparam logic [31:0] TW = tw_entry(g);
        assign tw_rom[g] = TW;
    end

    fsng_state_t state_reg, state_next;
    logic [AW-1:0]    idx_reg;
    logic [TW_AW-1:0] c_reg;
    logic [SW-1:0]    s_reg;
    logic             inv_reg;
    logic [19:0]      gate_threshold_reg;
    logic             za_reg, zb_reg;

    logic [79:0] mem [FRAME_SIZE];
    logic [79:0] rd_a_reg, rd_b_reg;
    logic [31:0] tw_reg;
    logic signed [56:0] prod_reg;
    logic signed [57:0] accr_reg, acci_reg;
    logic [55:0] sq_reg, thsq_reg;
    logic [56:0] sum_reg;

    logic          mem_we, mem_re;
    logic [AW-1:0] wr_addr, ra_a, ra_b;
    logic [79:0]   wr_data;
    logic signed [39:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [56:0] mul_res;
    logic [27:0] sq_op;
    logic [55:0] sq_res;

    // Butterfly addressing and twiddle index.
    logic [AW-1:0] c_ext, bmask, addr_a, addr_b;
    logic [TW_AW-1:0] tw_idx;
    assign c_ext  = AW'(c_reg);
    assign bmask  = (AW'(1) << s_reg) - AW'(1);
    assign addr_a = ((c_ext & ~bmask) << 1) | (c_ext & bmask);
    assign addr_b = addr_a | (AW'(1) << s_reg);
    assign tw_idx = TW_AW'((c_ext & bmask) << (LOG2N - 1 - int'(s_reg)));

    logic last_c, last_s, last_idx, accept, skip_pair;
    logic [AW-1:0] idx_rev;
    assign last_c   = (c_reg == TW_AW'(HALF_N - 1));
    assign last_s   = (s_reg == SW'(LOG2N - 1));
    assign last_idx = (idx_reg == AW'(FRAME_SIZE - 1));
    assign idx_rev  = bit_rev(idx_reg);
    assign accept   = start && (state_reg == ST_LOAD);
    assign skip_pair = (idx_rev < idx_reg);

    logic signed [39:0] a_re, a_im, b_re, b_im, wr_r, wi_r, vr, vi;
    logic signed [57:0] accr_rnd, acci_rnd;
    assign a_re = rd_a_reg[79:40];
    assign a_im = rd_a_reg[39:0];
    assign b_re = rd_b_reg[79:40];
    assign b_im = rd_b_reg[39:0];
    assign wr_r = 40'(signed'(tw_reg[31:16]));
    assign wi_r = inv_reg ? 40'(signed'(tw_reg[15:0])) : -40'(signed'(tw_reg[15:0]));
    assign accr_rnd = accr_reg + 58'sd16384;
    assign acci_rnd = acci_reg + 58'sd16384;
    assign vr = accr_rnd[54:15];
    assign vi = acci_rnd[54:15];

    logic [39:0] abs_are, abs_aim, abs_bre, abs_bim;
    logic small_a, small_b;
    assign abs_are = a_re[39] ? 40'(-a_re) : a_re;
    assign abs_aim = a_im[39] ? 40'(-a_im) : a_im;
    assign abs_bre = b_re[39] ? 40'(-b_re) : b_re;
    assign abs_bim = b_im[39] ? 40'(-b_im) : b_im;
    assign small_a = (abs_are[39:28] == 12'd0) && (abs_aim[39:28] == 12'd0);
    assign small_b = (abs_bre[39:28] == 12'd0) && (abs_bim[39:28] == 12'd0);

    assign mul_res = mul_a * mul_b;
    assign sq_res  = sq_op * sq_op;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:   if (accept && last_idx) state_next = ST_BF_RD;
            ST_BF_RD:  state_next = ST_BF_M0;
            ST_BF_M0:  state_next = ST_BF_M1;
            ST_BF_M1:  state_next = ST_BF_M2;
            ST_BF_M2:  state_next = ST_BF_M3;
            ST_BF_M3:  state_next = ST_BF_M4;
            ST_BF_M4:  state_next = ST_BF_WA;
            ST_BF_WA:  state_next = ST_BF_WB;
            ST_BF_WB:
            begin
                if (!(last_c && last_s))
                    state_next = ST_BF_RD;
                else if (inv_reg)
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_GT_TH;
            end
            ST_GT_TH:  state_next = ST_GT_RD;
            ST_GT_RD:
            begin
                if (!skip_pair)
                    state_next = ST_GT_S0;
                else if (last_idx)
                    state_next = ST_BF_RD;
            end
            ST_GT_S0:  state_next = ST_GT_S1;
            ST_GT_S1:  state_next = ST_GT_S2;
            ST_GT_S2:  state_next = ST_GT_S3;
            ST_GT_S3:  state_next = ST_GT_S4;
            ST_GT_S4:  state_next = ST_GT_WA;
            ST_GT_WA:  state_next = ST_GT_WB;
            ST_GT_WB:  state_next = last_idx ? ST_BF_RD : ST_GT_RD;
            ST_OUT_RD: state_next = ST_OUT_EM;
            ST_OUT_EM: state_next = last_idx ? ST_LOAD : ST_OUT_RD;
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        wr_addr = addr_a;
        wr_data = {40'(vr + a_re), 40'(vi + a_im)};
        ra_a    = addr_a;
        ra_b    = addr_b;
        mul_a   = b_re;
        mul_b   = 17'(wr_r);
        sq_op   = abs_are[27:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                mem_we  = accept;
                wr_addr = idx_rev;
                wr_data = {{16{sample[15]}}, sample, 8'h00, 40'd0};
            end
            ST_BF_RD:  mem_re = 1'b1;
            ST_BF_M0:
            begin
                mul_a = b_re;
                mul_b = 17'(wr_r);
            end
            ST_BF_M1:
            begin
                mul_a = b_im;
                mul_b = 17'(wi_r);
            end
            ST_BF_M2:
            begin
                mul_a = b_re;
                mul_b = 17'(wi_r);
            end
            ST_BF_M3:
            begin
                mul_a = b_im;
                mul_b = 17'(wr_r);
            end
            ST_BF_WA:  mem_we = 1'b1;
            ST_BF_WB:
            begin
                mem_we  = 1'b1;
                wr_addr = addr_b;
                wr_data = {40'(a_re - vr), 40'(a_im - vi)};
            end
            ST_GT_TH:  sq_op = {gate_threshold_reg, 8'h00};
            ST_GT_RD:
            begin
                mem_re = !skip_pair;
                ra_a   = idx_reg;
                ra_b   = idx_rev;
            end
            ST_GT_S0:  sq_op = abs_are[27:0];
            ST_GT_S1:  sq_op = abs_aim[27:0];
            ST_GT_S2:  sq_op = abs_bre[27:0];
            ST_GT_S3:  sq_op = abs_bim[27:0];
            ST_GT_WA:
            begin
                mem_we  = 1'b1;
                wr_addr = idx_rev;
                wr_data = za_reg ? 80'd0 : rd_a_reg;
            end
            ST_GT_WB:
            begin
                mem_we  = 1'b1;
                wr_addr = idx_reg;
                wr_data = zb_reg ? 80'd0 : rd_b_reg;
            end
            ST_OUT_RD:
            begin
                mem_re = 1'b1;
                ra_a   = idx_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
        begin
            rd_a_reg <= mem[ra_a];
            rd_b_reg <= mem[ra_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BF_RD)
            tw_reg <= tw_rom[tw_idx];
        prod_reg <= mul_res;
        case (state_reg)
            ST_BF_M1: accr_reg <= 58'(prod_reg);
            ST_BF_M2: accr_reg <= accr_reg - 58'(prod_reg);
            ST_BF_M3: acci_reg <= 58'(prod_reg);
            ST_BF_M4: acci_reg <= acci_reg + 58'(prod_reg);
            default:  accr_reg <= accr_reg;
        endcase
        if (state_reg == ST_GT_TH)
            thsq_reg <= sq_res;
        sq_reg <= sq_res;
        if (state_reg == ST_GT_S1 || state_reg == ST_GT_S3)
            sum_reg <= 57'(sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_LOAD;
            idx_reg            <= '0;
            c_reg              <= '0;
            s_reg              <= '0;
            inv_reg            <= 1'b0;
            za_reg             <= 1'b0;
            zb_reg             <= 1'b0;
            gate_threshold_reg <= GATE_THRESHOLD_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                gate_threshold_reg <= cfg_data;
            if (state_reg == ST_GT_S2)
                za_reg <= small_a && ((sum_reg + 57'(sq_reg)) < 57'(thsq_reg));
            if (state_reg == ST_GT_S4)
                zb_reg <= small_b && ((sum_reg + 57'(sq_reg)) < 57'(thsq_reg));
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                        idx_reg <= idx_reg + AW'(1);
                    inv_reg <= 1'b0;
                end
                ST_BF_WB:
                begin
                    c_reg <= last_c ? '0 : c_reg + TW_AW'(1);
                    if (last_c)
                        s_reg <= last_s ? '0 : s_reg + SW'(1);
                end
                ST_GT_RD:
                begin
                    if (skip_pair)
                    begin
                        idx_reg <= idx_reg + AW'(1);
                        if (last_idx)
                            inv_reg <= 1'b1;
                    end
                end
                ST_GT_WB:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (last_idx)
                        inv_reg <= 1'b1;
                end
                ST_OUT_EM: idx_reg <= idx_reg + AW'(1);
                default:   idx_reg <= idx_reg;
            endcase
        end
    end

    // Output scaling by 1/N, rounding half away from zero and saturation.
    logic signed [39:0] scaled;
    logic [40:0] mag;
    logic [32:0] qmag;
    assign scaled = a_re >>> LOG2N;
    assign mag    = scaled[39] ? -41'(scaled) : 41'(scaled);
    assign qmag   = 33'((mag + 41'd128) >> 8);

    always_comb
    begin
        busy         = (state_reg != ST_LOAD);
        cfg_ready    = (state_reg == ST_LOAD);
        result_valid = (state_reg == ST_OUT_EM);
        last_in_frame = result_valid && last_idx;
        if (!scaled[39])
            cleaned_sample = (qmag > 33'd32767) ? 16'sh7fff : 16'(qmag);
        else
            cleaned_sample = (qmag > 33'd32768) ? 16'sh8000 : 16'(-qmag);
    end

`ifndef SYNTHESIS
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside processing");
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_idx) |=> busy)
        else $error("frame completion did not start processing");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy) && $past(rst_n)) |-> (idx_reg == '0))
        else $error("load index not cleared at frame start");
`endif

endmodule
